// File: design/unison_wavetable_oscillator_macros.svh
// ----------------------------------------------------------------------------
// Unison oscillator assertion macros
// Concurrent check wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef UNISON_WAVETABLE_OSCILLATOR_MACROS_SVH
`define UNISON_WAVETABLE_OSCILLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define UWO_ASSERT_IMPL(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define UWO_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define UWO_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define UWO_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: design/uwo_pkg.sv
// ----------------------------------------------------------------------------
// Unison oscillator package
// Shared constants, tables and waveform codes.
// ----------------------------------------------------------------------------
package uwo_pkg;
  localparam int DefSampleRate = 48000;
  localparam int DefMaxVoices  = 8;
  localparam int DefPhaseBits  = 32;

  localparam logic [2:0] WAVE_SINE  = 3'd0;
  localparam logic [2:0] WAVE_SAW   = 3'd1;
  localparam logic [2:0] WAVE_PULSE = 3'd2;
  localparam logic [2:0] WAVE_TRI   = 3'd3;
  localparam logic [2:0] WAVE_NOISE = 3'd4;

  localparam logic [2:0] REG_WAVE   = 3'd0;
  localparam logic [2:0] REG_PITCH  = 3'd1;
  localparam logic [2:0] REG_FINE   = 3'd2;
  localparam logic [2:0] REG_PHOFF  = 3'd3;
  localparam logic [2:0] REG_GAIN   = 3'd4;
  localparam logic [2:0] REG_PWIDTH = 3'd5;
  localparam logic [2:0] REG_SPREAD = 3'd6;
  localparam logic [2:0] REG_VCOUNT = 3'd7;

  localparam logic [31:0] LFSR_SEED = 32'h0000ACE1;
  localparam logic [31:0] LFSR_MASK = 32'h80200003;

  typedef struct packed {
    logic [2:0]         wave;
    logic signed [14:0] pitch;
    logic signed [14:0] fine;
    logic [15:0]        phoff;
    logic [15:0]        gain;
    logic [15:0]        pwidth;
    logic [11:0]        spread;
    logic [3:0]         vcount;
  } cfg_t;

  function automatic logic [16:0] semi_lut(input logic [3:0] s);
    case (s)
      4'd0: semi_lut = 17'd32768;   4'd1: semi_lut = 17'd34716;
      4'd2: semi_lut = 17'd36781;   4'd3: semi_lut = 17'd38969;
      4'd4: semi_lut = 17'd41285;   4'd5: semi_lut = 17'd43740;
      4'd6: semi_lut = 17'd46341;   4'd7: semi_lut = 17'd49097;
      4'd8: semi_lut = 17'd52016;   4'd9: semi_lut = 17'd55109;
      4'd10: semi_lut = 17'd58386;  4'd11: semi_lut = 17'd61858;
      4'd12: semi_lut = 17'd65536;
      default: semi_lut = 17'd65536;
    endcase
  endfunction

  function automatic logic [14:0] qsine_lut(input logic [4:0] s);
    case (s)
      5'd0: qsine_lut = 15'd0;      5'd1: qsine_lut = 15'd3212;
      5'd2: qsine_lut = 15'd6393;   5'd3: qsine_lut = 15'd9512;
      5'd4: qsine_lut = 15'd12539;  5'd5: qsine_lut = 15'd15446;
      5'd6: qsine_lut = 15'd18204;  5'd7: qsine_lut = 15'd20787;
      5'd8: qsine_lut = 15'd23170;  5'd9: qsine_lut = 15'd25329;
      5'd10: qsine_lut = 15'd27245; 5'd11: qsine_lut = 15'd28898;
      5'd12: qsine_lut = 15'd30273; 5'd13: qsine_lut = 15'd31356;
      5'd14: qsine_lut = 15'd32137; 5'd15: qsine_lut = 15'd32609;
      default: qsine_lut = 15'd32767;
    endcase
  endfunction
endpackage

// File: design/uwo_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered signed 33x18 product used by the detune, interpolation, reciprocal, sine and gain steps.
// ----------------------------------------------------------------------------
module uwo_mul import uwo_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [17:0] b,
  output logic signed [50:0] p
);
  always_ff @(posedge clk) begin
    p <= 51'(a) * 51'(b);
  end
endmodule

// File: design/uwo_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 48/18 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uwo_div import uwo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [17:0] den,
  output logic        busy,
  output logic [47:0] quo
);
  logic [5:0]  cnt;
  logic [18:0] rem;
  logic [18:0] trial;
  logic [17:0] dv;

  assign trial = {rem[17:0], quo[47]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd48;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (!trial[18]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= {rem[17:0], quo[47]};
        quo <= {quo[46:0], 1'b0};
      end
    end
  end
endmodule

// File: design/unison_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// Unison wavetable oscillator
// Bank of unison phase accumulators with shared arithmetic, one sample per accepted note.
// ----------------------------------------------------------------------------
// Usage: present note_pitch on the input channel (in_valid/in_stall); each
// accepted transaction advances every active voice once and yields exactly
// one sample_out on the output channel (out_valid/out_stall).
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; write them only while the block is idle.
// Each voice runs through the sequencer steps (sine has one more), with the
// bit-serial divider for the detune when more than one voice runs. The phase
// step comes from a reciprocal product in two passes through the one shared
// 33x18 multiplier. Averaging more than one voice adds another divider pass.
// Throughput: one item at a time; in_stall stays high while a sample is in
// work, and the next note can be taken in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls it holds,
// the block may accept the next note and waits at the gain step until the
// register frees. Reset: all phases clear, the noise register loads its
// seed, registers take their defaults; out_valid drops.
// ----------------------------------------------------------------------------
`include "unison_wavetable_oscillator_macros.svh"
module unison_wavetable_oscillator import uwo_pkg::*; #(
  parameter int SAMPLE_RATE = DefSampleRate,
  parameter int MAX_VOICES  = DefMaxVoices,
  parameter int PHASE_BITS  = DefPhaseBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [14:0]        note_pitch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);

  // 440*m<<24 / rate as (m * RCP_W) >> 35, exact for m < 2^17
  localparam longint unsigned RATE_K = 64'd440 << 24;
  localparam longint unsigned RCP_A  = RATE_K / 64'(SAMPLE_RATE);
  localparam longint unsigned RCP_B  = RATE_K % 64'(SAMPLE_RATE);
  localparam longint unsigned RCP_W  = (RCP_A << 35) + ((RCP_B << 35) / 64'(SAMPLE_RATE))
                                       + 64'd1;
  localparam logic [31:0] RCP_LO = RCP_W[31:0];
  localparam logic [31:0] RCP_HI = RCP_W[63:32];

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0, S_DET = 5'd1, S_DETW = 5'd2,
    S_OCT = 5'd3, S_INT = 5'd4, S_INTW = 5'd5, S_DIV = 5'd6, S_DIVW = 5'd7,
    S_PH = 5'd8, S_WAVE = 5'd9, S_SINW = 5'd10, S_ACC = 5'd11,
    S_AVG = 5'd12, S_AVGW = 5'd13, S_GAIN = 5'd14, S_GAINW = 5'd15,
    S_RCP = 5'd16, S_RCPW = 5'd17;

  cfg_t cfg;
  logic [4:0]  state;
  logic [VW-1:0] vi;
  logic [CW-1:0] nv;
  logic [14:0] note;
  logic [31:0] phase [MAX_VOICES];
  logic [31:0] lfsr;
  logic signed [21:0] sum;
  logic signed [17:0] xr;       // octave remainder of the re-based pitch
  logic signed [7:0]  oct;
  logic [16:0] mant;
  logic signed [16:0] wv;
  logic [17:0] rlo;
  logic [47:0] qr;
  logic        dsign;

  // shared multiplier
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] mp;
  uwo_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // shared divider: detune quotient and the voice average
  logic        dstart, dbusy;
  logic [47:0] dnum, dq;
  logic [17:0] dden;
  uwo_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
                 .busy(dbusy), .quo(dq));

  logic out_load;
  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  // load the output register when it is empty or drains this cycle
  assign out_load  = (state == S_GAINW) && (!out_valid || !out_stall);

  logic [CW-1:0] nv_sat;
  assign nv_sat = ({1'b0, cfg.vcount} > 5'(MAX_VOICES)) ? CW'(MAX_VOICES)
                                                         : CW'(cfg.vcount);

  // detune numerator spread*(2i-(V-1)), sign kept apart for the divider
  logic signed [6:0]  dk;
  logic signed [19:0] dnumer;
  assign dk = 7'sd2 * 7'($unsigned(vi)) - 7'($unsigned(nv)) + 7'sd1;

  // octave split of the re-based pitch (x + 64 octaves, nonnegative):
  // divide by 1024 with a shift, then by 3 with a reciprocal multiply
  logic [17:0] xo;
  logic [11:0] rrem;
  logic [6:0]  oq;
  always_comb begin
    oq = 7'((16'(xo[17:10]) * 16'd171) >> 9);
    rrem = 12'(xo - 18'(oq) * 18'd3072);
  end

  // phase update and offset
  logic [31:0] pmask, inc, newph, pfull;
  logic [15:0] u;
  logic signed [8:0] e;
  logic [63:0] incw;
  assign pmask = 32'((64'd1 << PHASE_BITS) - 64'd1);
  always_comb begin
    e = 9'(PHASE_BITS) - 9'sd39 + 9'(oct);
    if (!e[8]) incw = {16'd0, qr} << ((e > 9'sd20) ? 5'd20 : e[4:0]);
    else       incw = ((-e) >= 9'sd63) ? 64'd0 : ({16'd0, qr} >> 6'(-e));
    inc   = incw[31:0] & pmask;
    newph = (phase[vi] + inc) & pmask;
    pfull = (phase[vi] + ((32'(cfg.phoff) << (PHASE_BITS - 16)) & pmask)) & pmask;
    u     = 16'(pfull >> (PHASE_BITS - 16));
  end

  // sine geometry
  logic [14:0] spos;
  logic [4:0]  sseg;
  logic signed [16:0] sbase;
  assign spos = u[14] ? (15'd16384 - {1'b0, u[13:0]}) : {1'b0, u[13:0]};
  assign sseg = spos[14:10];

  logic [31:0] lfsr_next;
  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);

  logic signed [16:0] tri_v;
  logic [15:0] tabs;
  always_comb begin
    tabs  = u[15] ? (u - 16'd32768) : (16'd32768 - u);
    tri_v = (tabs == 16'd32768) ? 17'sd32767 : (17'sd2 * 17'(tabs) - 17'sd32768);
  end

  logic        dneg;
  logic [19:0] dmag;
  logic signed [31:0] gq;
  always_comb begin
    dnumer = 20'(mp);
    dneg   = dnumer[19];
    dmag   = dneg ? -dnumer : dnumer;
    gq     = 32'(mp >>> 15) + ((mp[50] && mp[14:0] != 15'd0) ? 32'sd1 : 32'sd0);
  end

  // interpolated semitone ratio, valid while the product of S_INT is out
  logic [16:0] mant_c;
  assign mant_c = 17'(semi_lut(xr[11:8])) + 17'(mp >>> 8);

  always_comb begin
    ma = '0; mb = '0; sbase = '0;
    dstart = 1'b0; dnum = '0; dden = '0;
    case (state)
      S_DET:  begin ma = 33'($unsigned(cfg.spread)); mb = 18'(dk); end
      S_DETW: begin
        dstart = (nv > CW'(1));
        dnum = 48'(dmag); dden = 18'(nv) * 18'd2 - 18'd2;
      end
      S_INT:  begin
        ma = 33'(semi_lut(4'(rrem[11:8] + 4'd1)) - semi_lut(rrem[11:8]));
        mb = 18'(rrem[7:0]);
      end
      S_INTW: begin ma = 33'(RCP_LO); mb = 18'(mant_c); end
      S_RCP:  begin ma = 33'(RCP_HI); mb = 18'(mant); end
      S_WAVE: begin
        sbase = 17'(qsine_lut(sseg));
        ma = 33'(qsine_lut(5'(sseg + 5'd1))) - 33'(sbase);
        mb = 18'(spos[9:0]);
      end
      S_AVG:  begin
        dstart = (nv > CW'(1));
        dnum = 48'(sum[21] ? -sum : sum); dden = 18'(nv);
      end
      // hold the gain product while the output register is occupied
      S_GAIN, S_GAINW: begin ma = 33'(wv); mb = 18'($unsigned(cfg.gain)); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{wave: 3'd0, pitch: '0, fine: '0, phoff: '0, gain: 16'd8192,
               pwidth: 16'd32768, spread: 12'd26, vcount: 4'd1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE:   cfg.wave   <= cfg_data[2:0];
        REG_PITCH:  cfg.pitch  <= cfg_data[14:0];
        REG_FINE:   cfg.fine   <= cfg_data[14:0];
        REG_PHOFF:  cfg.phoff  <= cfg_data;
        REG_GAIN:   cfg.gain   <= cfg_data;
        REG_PWIDTH: cfg.pwidth <= cfg_data;
        REG_SPREAD: cfg.spread <= cfg_data[11:0];
        REG_VCOUNT: cfg.vcount <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic signed [17:0] det;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      lfsr <= LFSR_SEED;
      for (int k = 0; k < MAX_VOICES; k++) phase[k] <= '0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          note <= note_pitch; nv <= nv_sat; vi <= '0; sum <= '0;
          state <= (nv_sat == '0) ? S_AVG : S_DET;
        end
        S_DET:  state <= S_DETW;
        S_DETW: begin
          det <= '0;
          dsign <= dneg;
          state <= (nv > CW'(1)) ? S_DIV : S_OCT;
          xo <= '0;
        end
        S_DIV:  state <= S_DIVW;
        S_DIVW: if (!dbusy) begin
          det <= dsign ? -18'(dq) : 18'(dq);
          state <= S_OCT;
        end
        S_OCT: begin
          xo <= 18'(18'sd3072 * 18'sd64 + 18'(note) + 18'(cfg.pitch) + 18'(cfg.fine)
                + det - 18'sd17664);
          state <= S_INT;
        end
        S_INT: begin
          oct <= 8'(oq) - 8'sd64;
          state <= S_INTW;
        end
        S_INTW: state <= S_RCP;
        S_RCP: begin
          rlo <= 18'(mp >>> 32);
          state <= S_RCPW;
        end
        S_RCPW: begin
          qr <= 48'((mp + 51'(rlo)) >>> 3);
          state <= S_PH;
        end
        S_PH: begin
          phase[vi] <= newph;
          state <= S_WAVE;
        end
        S_WAVE: begin
          case (cfg.wave)
            WAVE_SINE:  wv <= sbase;
            WAVE_SAW:   wv <= 17'(u) - 17'sd32768;
            WAVE_PULSE: wv <= (u < cfg.pwidth) ? 17'sd32767 : -17'sd32768;
            WAVE_TRI:   wv <= tri_v;
            WAVE_NOISE: begin
              lfsr <= lfsr_next;
              wv <= 17'(lfsr_next[31:16]) - 17'sd32768;
            end
            default:    wv <= '0;
          endcase
          state <= (cfg.wave == WAVE_SINE) ? S_SINW : S_ACC;
        end
        S_SINW: begin
          wv <= wv + 17'(mp >>> 10);
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum + 22'(((cfg.wave == WAVE_SINE) && u[15]) ? -wv : wv);
          if (32'(vi) == 32'(nv) - 1) state <= S_AVG;
          else begin vi <= vi + VW'(1); state <= S_DET; end
        end
        S_AVG:  state <= S_AVGW;
        S_AVGW: if (!dbusy) begin
          if (nv > CW'(1)) wv <= 17'(sum[21] ? -22'(dq) : 22'(dq));
          else wv <= 17'(sum);
          state <= S_GAIN;
        end
        S_GAIN: state <= S_GAINW;
        S_GAINW: if (out_load) begin
          sample_out <= (gq > 32'sd32767) ? 16'sd32767 :
                        (gq < -32'sd32768) ? -16'sd32768 : 16'(gq);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_INT uses remainder; xo registered in S_OCT
  always_ff @(posedge clk) begin
    xr <= 18'(rrem);
    if (state == S_INTW) mant <= mant_c;
  end

  `UWO_ASSERT_IMPL(a_stall_busy, clk, rst, state != S_IDLE, in_stall)
  `UWO_ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_ready, state == S_IDLE)
  `UWO_ASSERT_NEXT(a_one_out, clk, rst, out_load, out_valid)
  `UWO_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sample_out))
endmodule
